// ===== hw/rtl/mncc_pkg.sv =====
// Shared types and constants of the multi-node charge counter.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none
package mncc_pkg;

	// table geometry
	localparam int NODES  = 64;
	localparam int NODE_W = $clog2(NODES);

	// field widths
	localparam int CHG_W  = 48;
	localparam int TIME_W = 40;
	localparam int CUR_W  = 20;
	localparam int DUR_W  = 24;
	localparam int FRAC_W = 17;
	localparam int CAP_W  = 16;
	localparam int VOLT_W = 16;
	localparam int LVL_W  = 17;
	localparam int NRG_W  = 44;
	localparam int OPC_W  = 3;
	localparam int CFGI_W = 3;

	// serial divider geometry
	localparam int DIVD_W    = 65;
	localparam int DIVS_W    = 48;
	localparam int DIV_STEPS = DIVD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// energy divide: 2000000 = 128 * 15625, long division in 12-bit digits
	localparam int NRG_SHIFT = 7;
	localparam int NDIG_W    = 12;
	localparam int NDIGITS   = 5;
	localparam int NY_W      = NDIG_W * NDIGITS;
	localparam int RCP_SH    = 40;
	localparam logic [13:0] ENERGY_K   = 14'd15625;
	// ceil(2^40 / 15625), exact for a 26-bit partial dividend
	localparam logic [26:0] ENERGY_RCP = 27'd70368745;

	// 1 mAh = 3600000000 uA*ms = 3515625 * 1024
	localparam logic [21:0]       UAMS_K     = 22'd3515625;
	localparam logic [LVL_W-1:0]  LEVEL_ONE  = 17'd65536;

	// opcodes
	localparam logic [OPC_W-1:0] OP_REGISTER = 3'd0;
	localparam logic [OPC_W-1:0] OP_SET_FRAC = 3'd1;
	localparam logic [OPC_W-1:0] OP_TRANSMIT = 3'd2;
	localparam logic [OPC_W-1:0] OP_RECEIVE  = 3'd3;
	localparam logic [OPC_W-1:0] OP_CAD      = 3'd4;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_CAPACITY = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_TX_CUR   = 3'd1;
	localparam logic [CFGI_W-1:0] CFG_RX_CUR   = 3'd2;
	localparam logic [CFGI_W-1:0] CFG_CAD_CUR  = 3'd3;
	localparam logic [CFGI_W-1:0] CFG_IDLE_CUR = 3'd4;
	localparam logic [CFGI_W-1:0] CFG_VLOW     = 3'd5;
	localparam logic [CFGI_W-1:0] CFG_VHIGH    = 3'd6;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_PREP, S_DR_LO, S_DR_HI, S_APPLY, S_ACT, S_WRITE,
		S_SUM, S_DSTART, S_DWAIT, S_LVL, S_VOLT, S_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic read;
		logic prep;
		logic drain_lo;
		logic drain_hi;
		logic apply;
		logic act;
		logic write;
		logic esum;
		logic div_start;
		logic lvl;
		logic volt;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mncc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on mncc_pkg.
`default_nettype none
module mncc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mncc_pkg::DIVD_W-1:0] dividend,
	input  wire logic [mncc_pkg::DIVS_W-1:0] divisor,
	output logic                             done,
	output logic [mncc_pkg::DIVD_W-1:0]      quotient
);
	import mncc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	// next partial remainder with one dividend bit shifted in
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/mncc_ctrl.sv =====
// Sequencing state machine of the charge counter.
// Depends on mncc_pkg.
`default_nettype none
module mncc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mncc_pkg::sts_t sts,
	output mncc_pkg::cmd_t     cmd
);
	import mncc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_READ;
			S_READ:   state_d = S_PREP;
			S_PREP:   state_d = S_DR_LO;
			S_DR_LO:  state_d = S_DR_HI;
			S_DR_HI:  state_d = S_APPLY;
			S_APPLY:  state_d = S_ACT;
			S_ACT:    state_d = S_WRITE;
			S_WRITE:  state_d = S_SUM;
			S_SUM:    state_d = S_DSTART;
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT:  if (sts.div_done) state_d = S_LVL;
			S_LVL:    state_d = S_VOLT;
			S_VOLT:   state_d = S_OUT;
			S_OUT:    if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_READ:   cmd.read      = 1'b1;
			S_PREP:   cmd.prep      = 1'b1;
			S_DR_LO:  cmd.drain_lo  = 1'b1;
			S_DR_HI:  cmd.drain_hi  = 1'b1;
			S_APPLY:  cmd.apply     = 1'b1;
			S_ACT:    cmd.act       = 1'b1;
			S_WRITE:  cmd.write     = 1'b1;
			S_SUM:    cmd.esum      = 1'b1;
			S_DSTART: cmd.div_start = 1'b1;
			S_DWAIT:  cmd           = '0;
			S_LVL:    cmd.lvl       = 1'b1;
			S_VOLT:   cmd.volt      = 1'b1;
			S_OUT:    cmd.out_load  = !sts.out_busy;
			default:  cmd           = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mncc_dp.sv =====
// Datapath of the charge counter: configuration, node tables, arithmetic,
// the level divider, the energy divide and the output register.
// Depends on mncc_pkg, mncc_div.
`default_nettype none
module mncc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mncc_pkg::cmd_t                cmd,
	output mncc_pkg::sts_t                     sts,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mncc_pkg::CFGI_W-1:0]   cfg_index,
	input  wire logic [mncc_pkg::CUR_W-1:0]    cfg_data,
	input  wire logic [mncc_pkg::OPC_W-1:0]    opcode,
	input  wire logic [mncc_pkg::NODE_W-1:0]   node,
	input  wire logic [mncc_pkg::TIME_W-1:0]   now_ms,
	input  wire logic [mncc_pkg::CUR_W-1:0]    current_ua,
	input  wire logic [mncc_pkg::DUR_W-1:0]    duration_ms,
	input  wire logic [mncc_pkg::FRAC_W-1:0]   fraction_q16,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mncc_pkg::CHG_W-1:0]         remaining_charge,
	output logic [mncc_pkg::LVL_W-1:0]         level_q16,
	output logic [mncc_pkg::VOLT_W-1:0]        voltage_mv,
	output logic [mncc_pkg::NRG_W-1:0]         energy_uj,
	output logic                               was_new
);
	import mncc_pkg::*;

	function automatic logic [CHG_W-1:0] sub_sat(input logic [CHG_W-1:0] a,
		input logic [59:0] b);
		return ({12'b0, a} > b) ? CHG_W'(a - b[CHG_W-1:0]) : '0;
	endfunction

	// configuration registers
	logic [CAP_W-1:0]  cap_q;
	logic [CUR_W-1:0]  tx_q, rx_q, cad_q, idle_q;
	logic [VOLT_W-1:0] vlow_q, vhigh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= 16'd2000;
			tx_q    <= 20'd120000;
			rx_q    <= 20'd11000;
			cad_q   <= 20'd11000;
			idle_q  <= 20'd1500;
			vlow_q  <= 16'd3000;
			vhigh_q <= 16'd4200;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CAPACITY: cap_q   <= cfg_data[CAP_W-1:0];
				CFG_TX_CUR:   tx_q    <= cfg_data;
				CFG_RX_CUR:   rx_q    <= cfg_data;
				CFG_CAD_CUR:  cad_q   <= cfg_data;
				CFG_IDLE_CUR: idle_q  <= cfg_data;
				CFG_VLOW:     vlow_q  <= cfg_data[VOLT_W-1:0];
				CFG_VHIGH:    vhigh_q <= cfg_data[VOLT_W-1:0];
				default:      cap_q   <= cap_q;
			endcase
		end
	end

	logic [CAP_W-1:0] cap_eff;
	assign cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;

	// captured item
	logic [OPC_W-1:0]  op_q;
	logic [NODE_W-1:0] node_q;
	logic [TIME_W-1:0] now_q;
	logic [CUR_W-1:0]  cur_q;
	logic [DUR_W-1:0]  dur_q;
	logic [FRAC_W-1:0] frac_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			node_q <= node;
			now_q  <= now_ms;
			cur_q  <= current_ua;
			dur_q  <= duration_ms;
			frac_q <= fraction_q16;
		end
	end

	// node tables, read on transfer, written once per item
	logic [CHG_W-1:0]  charge_mem [NODES];
	logic [TIME_W-1:0] time_mem [NODES];
	logic [CHG_W-1:0]  rd_chg_q;
	logic [TIME_W-1:0] rd_tim_q;
	logic [NODES-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_chg_q <= charge_mem[node];
			rd_tim_q <= time_mem[node];
		end
	end

	// working registers
	logic [CHG_W-1:0]  full_q;
	logic [38:0]       frk_q;
	logic [43:0]       act_q;
	logic [TIME_W-1:0] tim_q;
	logic              new_q;
	logic [CHG_W-1:0]  chg_q;
	logic [54:0]       sf_q;
	logic              late_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [39:0]       dlo_q;
	logic [59:0]       drain_q;
	logic [40:0]       elo_q, ehi_q;
	logic [DIVD_W-1:0] eprod_q;
	logic [LVL_W-1:0]  level_q;
	logic [NRG_W-1:0]  energy_q;
	logic [VOLT_W-1:0] volt_q;

	logic [FRAC_W-1:0] frac_cl;
	logic [CUR_W-1:0]  cur_sel;
	logic [37:0]       full_k;
	logic [39:0]       dhi;
	logic [16:0]       vsum;
	logic [VOLT_W-1:0] vmin, vmax;
	logic [32:0]       vprod;
	logic              is_activity;

	assign frac_cl = (frac_q > LEVEL_ONE) ? LEVEL_ONE : frac_q;
	assign full_k  = 38'(cap_eff) * 38'(UAMS_K);
	assign dhi     = 40'(idle_q) * 40'(elapsed_q[39:20]);
	assign vsum    = 17'(vlow_q) + 17'(vhigh_q);
	assign vmin    = (vlow_q < vhigh_q) ? vlow_q : vhigh_q;
	assign vmax    = (vlow_q < vhigh_q) ? vhigh_q : vlow_q;
	assign vprod   = 33'(vmax - vmin) * 33'(level_q);
	assign is_activity = (op_q == OP_TRANSMIT) || (op_q == OP_RECEIVE) || (op_q == OP_CAD);

	// activity current by opcode
	always_comb begin
		case (op_q)
			OP_TRANSMIT: cur_sel = (cur_q != '0) ? cur_q : tx_q;
			OP_RECEIVE:  cur_sel = rx_q;
			default:     cur_sel = cad_q;
		endcase
	end

	// level divider
	logic              lvl_done;
	logic [DIVD_W-1:0] lvl_quo;

	mncc_div u_lvl_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({1'b0, chg_q, 16'b0}),
		.divisor  (full_q),
		.done     (lvl_done),
		.quotient (lvl_quo)
	);

	// energy divide by 2000000: drop the factor 128 by a shift, then long
	// division by 15625 in 12-bit digits, each digit in turn: first the quotient
	// digit by reciprocal multiplication, then the partial remainder
	logic [NY_W-1:0]   ny_q;
	logic [NY_W-1:0]   nq_q;
	logic [13:0]       nr_q;
	logic [NDIG_W-1:0] nqd_q;
	logic [2:0]        ncnt_q;
	logic              nph_q;
	logic              nbusy_q;
	logic              ndone_q;
	logic [25:0]       nt;
	logic [52:0]       nt_prod;
	logic [25:0]       nt_rem;

	assign nt      = {nr_q, ny_q[NY_W-1 -: NDIG_W]};
	assign nt_prod = 53'(nt) * 53'(ENERGY_RCP);
	assign nt_rem  = nt - 26'(nqd_q) * 26'(ENERGY_K);

	// energy divide step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbusy_q <= 1'b0;
			ndone_q <= 1'b0;
			ncnt_q  <= '0;
			nph_q   <= 1'b0;
		end else if (cmd.div_start) begin
			nbusy_q <= 1'b1;
			ndone_q <= 1'b0;
			ncnt_q  <= '0;
			nph_q   <= 1'b0;
		end else if (nbusy_q) begin
			nph_q <= !nph_q;
			if (nph_q) begin
				ncnt_q <= ncnt_q + 1'b1;
				if (ncnt_q == 3'(NDIGITS - 1)) begin
					nbusy_q <= 1'b0;
					ndone_q <= 1'b1;
				end
			end
		end
	end

	// energy divide digits
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			ny_q <= NY_W'(eprod_q[DIVD_W-1:NRG_SHIFT]);
			nq_q <= '0;
			nr_q <= '0;
		end else if (nbusy_q) begin
			if (!nph_q) begin
				nqd_q <= nt_prod[RCP_SH +: NDIG_W];
			end else begin
				nr_q <= nt_rem[13:0];
				ny_q <= {ny_q[NY_W-NDIG_W-1:0], {NDIG_W{1'b0}}};
				nq_q <= {nq_q[NY_W-NDIG_W-1:0], nqd_q};
			end
		end
	end

	// step-by-step arithmetic
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			full_q <= {full_k, 10'b0};
			frk_q  <= 39'(frac_cl) * 39'(UAMS_K);
			act_q  <= 44'(cur_sel) * 44'(dur_q);
			tim_q  <= valid_q[node_q] ? rd_tim_q : now_q;
			new_q  <= !valid_q[node_q];
		end
		if (cmd.prep) begin
			chg_q     <= new_q ? full_q : rd_chg_q;
			sf_q      <= 55'(frk_q) * 55'(cap_eff);
			late_q    <= tim_q < now_q;
			elapsed_q <= now_q - tim_q;
		end
		if (cmd.drain_lo) begin
			dlo_q <= 40'(idle_q) * 40'(elapsed_q[19:0]);
		end
		if (cmd.drain_hi) begin
			drain_q <= 60'(dlo_q) + {dhi, 20'b0};
		end
		if (cmd.apply) begin
			case (op_q)
				OP_REGISTER: tim_q <= now_q;
				OP_SET_FRAC: begin
					chg_q <= sf_q[53:6];
					tim_q <= now_q;
				end
				default: begin
					if (late_q) chg_q <= sub_sat(chg_q, drain_q);
					if (late_q || is_activity) tim_q <= now_q;
				end
			endcase
		end
		if (cmd.act && is_activity) begin
			chg_q <= sub_sat(chg_q, {16'b0, act_q});
		end
		if (cmd.write) begin
			charge_mem[node_q] <= chg_q;
			time_mem[node_q]   <= tim_q;
			elo_q <= 41'(chg_q[23:0]) * 41'(vsum);
			ehi_q <= 41'(chg_q[47:24]) * 41'(vsum);
		end
		if (cmd.esum) begin
			eprod_q <= 65'(elo_q) + {ehi_q, 24'b0};
		end
		if (cmd.lvl) begin
			level_q  <= (chg_q >= full_q) ? LEVEL_ONE : lvl_quo[LVL_W-1:0];
			energy_q <= (|nq_q[NY_W-1:NRG_W]) ? {NRG_W{1'b1}} : nq_q[NRG_W-1:0];
		end
		if (cmd.volt) begin
			volt_q <= vmin + vprod[31:16];
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write) begin
			valid_q[node_q] <= 1'b1;
		end
	end

	// output register
	logic              out_valid_q;
	logic [CHG_W-1:0]  out_chg_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic [VOLT_W-1:0] out_volt_q;
	logic [NRG_W-1:0]  out_nrg_q;
	logic              out_new_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_chg_q  <= chg_q;
			out_lvl_q  <= level_q;
			out_volt_q <= volt_q;
			out_nrg_q  <= energy_q;
			out_new_q  <= new_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign remaining_charge = out_chg_q;
	assign level_q16        = out_lvl_q;
	assign voltage_mv       = out_volt_q;
	assign energy_uj        = out_nrg_q;
	assign was_new          = out_new_q;

	assign sts.div_done = lvl_done && ndone_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/multi_node_charge_counter_top.sv =====
// Top level of the multi-node charge counter.
// Depends on mncc_pkg, mncc_ctrl, mncc_dp (and through it mncc_div).
//
// Per-node coulomb counter for 64 nodes. Events are handled one at a time: the
// result is offered in the same cycle that the next event can first be taken. The
// 65-step serial divider for the level fraction is the longest part of the sequence;
// the energy divide by 2000000 runs beside it in ten steps, and fourteen sequencing
// steps cover the transfer, table read, idle drain, activity charge, table write,
// energy sum, level, voltage and output load. The sequence stalls at the output step
// while the previous result still waits unaccepted. A new event is taken while the
// previous result still waits in the output register. Configuration writes are
// taken in any cycle (cfg_ready is always high) but must only be made while no
// event is in flight.
// Node entries are created full on first touch; there is no clearing pass.
`default_nettype none
module multi_node_charge_counter_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [mncc_pkg::CFGI_W-1:0] cfg_index,
	input  wire logic [mncc_pkg::CUR_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mncc_pkg::OPC_W-1:0]  opcode,
	input  wire logic [mncc_pkg::NODE_W-1:0] node,
	input  wire logic [mncc_pkg::TIME_W-1:0] now_ms,
	input  wire logic [mncc_pkg::CUR_W-1:0]  current_ua,
	input  wire logic [mncc_pkg::DUR_W-1:0]  duration_ms,
	input  wire logic [mncc_pkg::FRAC_W-1:0] fraction_q16,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mncc_pkg::CHG_W-1:0]       remaining_charge,
	output logic [mncc_pkg::LVL_W-1:0]       level_q16,
	output logic [mncc_pkg::VOLT_W-1:0]      voltage_mv,
	output logic [mncc_pkg::NRG_W-1:0]       energy_uj,
	output logic                             was_new
);
	import mncc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mncc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and storage
	mncc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.node             (node),
		.now_ms           (now_ms),
		.current_ua       (current_ua),
		.duration_ms      (duration_ms),
		.fraction_q16     (fraction_q16),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.remaining_charge (remaining_charge),
		.level_q16        (level_q16),
		.voltage_mv       (voltage_mv),
		.energy_uj        (energy_uj),
		.was_new          (was_new)
	);

endmodule
`default_nettype wire
